[src/frame_difference_motion_detector_macros.svh]
// assertion macros used by the checker file
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FDMD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdmd assertion failed");

// next-cycle implication, disabled during reset
`define FDMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdmd assertion failed");

`endif

[src/fdmd_pkg.sv]
// shared constants, register indexes and helper functions of the motion detector
`default_nettype none

package fdmd_pkg;

  localparam int MAX_WIDTH    = 320;
  localparam int MAX_HEIGHT   = 240;
  localparam int FRAME_PIXELS = MAX_WIDTH * MAX_HEIGHT;

  localparam int POS_W   = $clog2(FRAME_PIXELS);
  localparam int CNT_W   = $clog2(FRAME_PIXELS + 1);
  localparam int SCORE_W = 7;
  localparam int DIV_W   = CNT_W + SCORE_W;
  localparam int BIT_W   = $clog2(SCORE_W);

  localparam int SCORE_SCALE = 100;

  localparam int WIDTH_W = 9;
  localparam int HEIGHT_W = 8;
  localparam int LUMA_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DELTA     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESHOLD = 2'd3;

  localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH     = 9'd320;
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT    = 8'd240;
  localparam logic [LUMA_W-1:0]   RST_PIXEL_DELTA     = 8'd24;
  localparam logic [SCORE_W-1:0]  RST_RATIO_THRESHOLD = 7'd2;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    if (v == '0) return WIDTH_W'(1);
    if (32'(v) > MAX_WIDTH) return WIDTH_W'(MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    if (v == '0) return HEIGHT_W'(1);
    if (32'(v) > MAX_HEIGHT) return HEIGHT_W'(MAX_HEIGHT);
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] frame_total(input logic [WIDTH_W-1:0] w,
                                                  input logic [HEIGHT_W-1:0] h);
    logic [WIDTH_W+HEIGHT_W-1:0] prod;
    prod = {{HEIGHT_W{1'b0}}, clamp_width(w)} * {{WIDTH_W{1'b0}}, clamp_height(h)};
    return CNT_W'(prod);
  endfunction

endpackage

`default_nettype wire

[src/fdmd_ram.sv]
// generic simple dual-port ram with one write port and a registered read port
`default_nettype none

module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/frame_difference_motion_detector.sv]
// Frame-difference motion detector: takes one 8-bit luma pixel per transaction in raster order
// and compares it with the co-located pixel of a reference frame held in a 76800 x 8 block ram
// (read at the pixel's address as it is taken, then overwritten with the new pixel). One result
// comes out per frame: changed percentage, motion flag and a learning flag; the first frame
// after reset or after a width or height write is only stored and reported as learned. Pixels
// stream at one per clock. The score divider is a 7-step restoring divider; after its setup
// state it runs its steps and the result is then loaded into the output register. The last
// pixel of the next frame is held off until the divider is idle again (which also waits for a
// stalled result to leave), so a frame shorter than the divider's run streams at a lower rate.
// The ram needs no clearing pass, since an entry is compared only after it has been written.
`default_nettype none

module frame_difference_motion_detector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // s_tdata: [7:0] pixel_luma
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,
  // m_tdata: [6:0] score_pct, [7] motion_flag, [8] reference_learned, [15:9] zero
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [15:0]                   m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdmd_pkg::*;

  typedef enum logic [1:0] {DIV_IDLE, DIV_MUL, DIV_RUN, DIV_DONE} div_state_t;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [LUMA_W-1:0]   pixel_delta;
  logic [SCORE_W-1:0]  ratio_threshold;
  logic [CNT_W-1:0]    total;

  logic [POS_W-1:0]    pos;
  logic [CNT_W-1:0]    pos_inc;
  logic                in_last;
  logic                accept;
  logic                size_write;
  logic                ref_valid;
  logic [CNT_W-1:0]    changed_count;

  logic                s1_valid;
  logic                s1_last;
  logic [POS_W-1:0]    s1_addr;
  logic [LUMA_W-1:0]   s1_pix;
  logic                fwd;
  logic [LUMA_W-1:0]   fwd_data;
  logic [LUMA_W-1:0]   rd_data;
  logic [LUMA_W-1:0]   ref_pix;
  logic [LUMA_W-1:0]   diff;
  logic                hit;
  logic [CNT_W-1:0]    changed_final;

  div_state_t          div_state;
  logic [CNT_W-1:0]    div_den;
  logic [CNT_W-1:0]    div_count;
  logic [DIV_W-1:0]    div_num;
  logic [DIV_W-1:0]    div_trial;
  logic [SCORE_W-1:0]  div_q;
  logic [BIT_W-1:0]    div_bit;
  logic                div_learn;
  logic                out_load;

  logic [SCORE_W-1:0]  out_score;
  logic                out_motion;
  logic                out_learned;

  assign pos_inc  = CNT_W'(pos) + CNT_W'(1);
  assign in_last  = pos_inc >= total;
  // hold off a frame's last pixel while the score path is still busy
  assign s_tready = !(in_last && ((s1_valid && s1_last) || div_state != DIV_IDLE));
  assign accept   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign size_write = cfg_valid && cfg_ready &&
                      (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});

  fdmd_ram #(
    .WIDTH (LUMA_W),
    .DEPTH (FRAME_PIXELS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_pix),
    .raddr (pos),
    .rdata (rd_data)
  );

  // read-during-write on the same entry (one-pixel frames) takes the pixel just written
  assign ref_pix = fwd ? fwd_data : rd_data;
  assign diff    = (s1_pix > ref_pix) ? (s1_pix - ref_pix) : (ref_pix - s1_pix);
  assign hit     = ref_valid && (diff >= pixel_delta);
  assign changed_final = changed_count + CNT_W'(hit);

  assign div_trial = DIV_W'(div_den) << div_bit;
  assign out_load  = (div_state == DIV_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      pixel_delta     <= RST_PIXEL_DELTA;
      ratio_threshold <= RST_RATIO_THRESHOLD;
      total           <= frame_total(RST_FRAME_WIDTH, RST_FRAME_HEIGHT);
      pos             <= '0;
      ref_valid       <= 1'b0;
      changed_count   <= '0;
      s1_valid        <= 1'b0;
      fwd             <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd      <= accept && s1_valid && (s1_addr == pos);
      // a size write restarts the frame and drops the reference
      if (size_write) begin
        pos           <= '0;
        changed_count <= '0;
        ref_valid     <= 1'b0;
      end else begin
        if (accept) begin
          pos <= in_last ? '0 : pos_inc[POS_W-1:0];
        end
        if (s1_valid) begin
          if (s1_last) begin
            changed_count <= '0;
            ref_valid     <= 1'b1;
          end else begin
            changed_count <= changed_final;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[WIDTH_W-1:0];
            total       <= frame_total(cfg_data[WIDTH_W-1:0], frame_height);
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[HEIGHT_W-1:0];
            total        <= frame_total(frame_width, cfg_data[HEIGHT_W-1:0]);
          end
          REG_PIXEL_DELTA:     pixel_delta     <= cfg_data[LUMA_W-1:0];
          REG_RATIO_THRESHOLD: ratio_threshold <= cfg_data[SCORE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= pos;
      s1_pix   <= s_tdata;
      s1_last  <= in_last;
      fwd_data <= s1_pix;
    end
  end

  // end-of-frame score: changed * 100 / total, restoring division over quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (div_state)
        DIV_IDLE: begin
          if (s1_valid && s1_last) begin
            div_den   <= total;
            div_count <= changed_final;
            div_learn <= !ref_valid;
            div_state <= DIV_MUL;
          end
        end
        DIV_MUL: begin
          div_num   <= DIV_W'(div_count) * DIV_W'(SCORE_SCALE);
          div_q     <= '0;
          div_bit   <= BIT_W'(SCORE_W - 1);
          div_state <= DIV_RUN;
        end
        DIV_RUN: begin
          if (div_num >= div_trial) begin
            div_num        <= div_num - div_trial;
            div_q[div_bit] <= 1'b1;
          end
          if (div_bit == '0) begin
            div_state <= DIV_DONE;
          end else begin
            div_bit <= div_bit - BIT_W'(1);
          end
        end
        DIV_DONE: begin
          if (out_load) begin
            out_score   <= div_learn ? '0 : div_q;
            out_motion  <= !div_learn && (div_q >= ratio_threshold);
            out_learned <= div_learn;
            div_state   <= DIV_IDLE;
          end
        end
        default: div_state <= DIV_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, out_learned, out_motion, out_score};

endmodule

`default_nettype wire

[src/fdmd_checker.sv]
// port-level checker for the motion detector and its bind to the top level
`default_nettype none
`include "frame_difference_motion_detector_macros.svh"

module fdmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // a stalled result transaction holds its payload
  `FDMD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // a learned frame reports no score and no motion
  `FDMD_ASSERT_IMPL(a_learn_zero, clk, rst, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0)
  // score is a percentage
  `FDMD_ASSERT_IMPL(a_score_range, clk, rst, m_tvalid, m_tdata[6:0] <= 7'd100)
  // padding bits stay zero
  `FDMD_ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:9] == 7'd0)

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

`default_nettype wire
